// File: rtl/bmpu_pkg.sv
// Shared types and constants for the 24-bit BMP stream unpacker.
// Depends on nothing; used by bmpu_hdr_check and bmp_24bit_stream_unpacker.
`default_nettype none

package bmpu_pkg;

	// header layout (byte offsets into the file)
	localparam int unsigned HDR_BYTES  = 54;
	localparam int unsigned OFS_MAGIC0 = 0;
	localparam int unsigned OFS_MAGIC1 = 1;
	localparam int unsigned OFS_SIZE   = 2;
	localparam int unsigned OFS_DOFS   = 10;
	localparam int unsigned OFS_WIDTH  = 18;
	localparam int unsigned OFS_HEIGHT = 22;
	localparam int unsigned OFS_BPP    = 28;
	localparam int unsigned OFS_COMP   = 30;

	localparam logic [7:0]  MAGIC_B      = 8'h42;
	localparam logic [7:0]  MAGIC_M      = 8'h4D;
	localparam logic [15:0] BPP_24       = 16'd24;
	localparam logic [15:0] MAX_DIM_RST  = 16'd64000;

	// final status codes
	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_SHORT  = 3'd1,
		ST_MAGIC  = 3'd2,
		ST_SIZE   = 3'd3,
		ST_FORMAT = 3'd4,
		ST_OFFSET = 3'd5
	} status_t;

	// header summary handed to the pixel walker
	typedef struct packed {
		logic        pass;        // magic, format and offset all good
		logic [31:0] data_offset;
		logic [15:0] height;      // meaningful only when pass
		logic [17:0] used;        // width*3
		logic [17:0] padded;      // width*3 rounded up to 4
	} hdr_info_t;

endpackage

`default_nettype wire

// File: rtl/bmpu_hdr_check.sv
// Header field capture and header checks for the BMP stream unpacker.
// Depends on bmpu_pkg (hdr_info_t, status_t, header offsets).
`default_nettype none

module bmpu_hdr_check (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             capture,    // header byte consumed this cycle
	input  wire logic             clear,      // end of file: back to empty
	input  wire logic [5:0]       pos,        // header byte position
	input  wire logic [7:0]       data,
	input  wire logic [15:0]      max_dim,
	input  wire logic [32:0]      count_next, // saturating byte count after this word
	output bmpu_pkg::hdr_info_t   info,
	output bmpu_pkg::status_t     final_status
);

	logic [1:0]  magic_q;
	logic [31:0] size_q;
	logic [31:0] dofs_q;
	logic [31:0] width_q;
	logic [31:0] height_q;
	logic [15:0] bpp_q;
	logic        comp_q;
	logic [17:0] used_q;
	logic [17:0] padded_q;
	logic [33:0] prod_q;

	logic [1:0]  lane;
	logic        format_ok;
	logic        offset_ok;
	logic [34:0] end_pos;
	logic        short_next;

	// byte lane inside a 32-bit little-endian field
	always_comb begin
		priority if (pos >= 6'(bmpu_pkg::OFS_HEIGHT))
			lane = 2'(pos - 6'(bmpu_pkg::OFS_HEIGHT));
		else if (pos >= 6'(bmpu_pkg::OFS_WIDTH))
			lane = 2'(pos - 6'(bmpu_pkg::OFS_WIDTH));
		else if (pos >= 6'(bmpu_pkg::OFS_DOFS))
			lane = 2'(pos - 6'(bmpu_pkg::OFS_DOFS));
		else
			lane = 2'(pos - 6'(bmpu_pkg::OFS_SIZE));
	end

	// field capture, cleared at end of file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q  <= '0;
			size_q   <= '0;
			dofs_q   <= '0;
			width_q  <= '0;
			height_q <= '0;
			bpp_q    <= '0;
			comp_q   <= 1'b0;
		end else if (clear) begin
			magic_q  <= '0;
			size_q   <= '0;
			dofs_q   <= '0;
			width_q  <= '0;
			height_q <= '0;
			bpp_q    <= '0;
			comp_q   <= 1'b0;
		end else if (capture) begin
			if (pos == 6'(bmpu_pkg::OFS_MAGIC0) && data == bmpu_pkg::MAGIC_B)
				magic_q[0] <= 1'b1;
			if (pos == 6'(bmpu_pkg::OFS_MAGIC1) && data == bmpu_pkg::MAGIC_M)
				magic_q[1] <= 1'b1;
			if (pos >= 6'(bmpu_pkg::OFS_SIZE) && pos < 6'(bmpu_pkg::OFS_SIZE + 4))
				size_q[{lane, 3'b000} +: 8] <= data;
			if (pos >= 6'(bmpu_pkg::OFS_DOFS) && pos < 6'(bmpu_pkg::OFS_DOFS + 4))
				dofs_q[{lane, 3'b000} +: 8] <= data;
			if (pos >= 6'(bmpu_pkg::OFS_WIDTH) && pos < 6'(bmpu_pkg::OFS_WIDTH + 4))
				width_q[{lane, 3'b000} +: 8] <= data;
			if (pos >= 6'(bmpu_pkg::OFS_HEIGHT) && pos < 6'(bmpu_pkg::OFS_HEIGHT + 4))
				height_q[{lane, 3'b000} +: 8] <= data;
			if (pos == 6'(bmpu_pkg::OFS_BPP))
				bpp_q[7:0] <= data;
			if (pos == 6'(bmpu_pkg::OFS_BPP + 1))
				bpp_q[15:8] <= data;
			if (pos >= 6'(bmpu_pkg::OFS_COMP) && pos < 6'(bmpu_pkg::OFS_COMP + 4)
				&& data != 8'd0)
				comp_q <= 1'b1;
		end
	end

	// row size and image size, settled long before byte 54;
	// only the low 16 bits matter once the dimension check passes
	always_ff @(posedge clk) begin
		used_q   <= {1'b0, width_q[15:0], 1'b0} + {2'b00, width_q[15:0]};
		padded_q <= (used_q + 18'd3) & ~18'd3;
		prod_q   <= padded_q * height_q[15:0];
	end

	// header checks, max_dim taken live
	always_comb begin
		format_ok = bpp_q == bmpu_pkg::BPP_24 && !comp_q
			&& width_q != '0 && height_q != '0
			&& width_q <= {16'd0, max_dim} && height_q <= {16'd0, max_dim};
		end_pos   = {3'b000, dofs_q} + {1'b0, prod_q};
		offset_ok = dofs_q >= 32'(bmpu_pkg::HDR_BYTES) && end_pos <= {3'b000, size_q};
	end

	assign info.pass        = magic_q == 2'b11 && format_ok && offset_ok;
	assign info.data_offset = dofs_q;
	assign info.height      = height_q[15:0];
	assign info.used        = used_q;
	assign info.padded      = padded_q;

	// status for the last word of the file
	assign short_next = count_next[32:6] == '0 && count_next[5:0] < 6'(bmpu_pkg::HDR_BYTES);

	always_comb begin
		priority if (short_next)
			final_status = bmpu_pkg::ST_SHORT;
		else if (magic_q != 2'b11)
			final_status = bmpu_pkg::ST_MAGIC;
		else if (count_next != {1'b0, size_q})
			final_status = bmpu_pkg::ST_SIZE;
		else if (!format_ok)
			final_status = bmpu_pkg::ST_FORMAT;
		else if (!offset_ok)
			final_status = bmpu_pkg::ST_OFFSET;
		else
			final_status = bmpu_pkg::ST_OK;
	end

endmodule

`default_nettype wire

// File: rtl/bmp_24bit_stream_unpacker.sv
// Top level of the 24-bit BMP stream unpacker: input register, pixel walker,
// result register and the max_dimension register. Depends on bmpu_pkg, bmpu_hdr_check.
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall   file_byte, last_byte
//  result    out        out_valid / out_stall pixel_valid, pixel_byte, stream_done, status
//  config    in         cfg_valid / cfg_ready cfg_data (max_dimension)
//
// One byte per cycle sustained while the result side does not stall; a result
// leaves through the input register, then the result register, the walker being
// one pass of counter updates and compares. Bytes that make no result leave nothing.
// Reset clears all stream state and loads max_dimension with 64000.
// A stalled result holds the walker; in_stall rises only when the input
// register is full and the result register cannot drain.
`default_nettype none

module bmp_24bit_stream_unpacker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input words
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  file_byte,
	input  wire logic        last_byte,
	// result words
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             pixel_valid,
	output logic [7:0]       pixel_byte,
	output logic             stream_done,
	output logic [2:0]       status,
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	logic [15:0] max_dim_q;
	logic [32:0] count_q;
	logic [17:0] row_pos_q;
	logic [15:0] rows_done_q;

	logic        blocked;
	logic        proc;
	logic        in_hdr;
	logic        walk;
	logic        emit;
	logic [17:0] row_inc;
	logic        row_end;
	logic [32:0] count_next;

	bmpu_pkg::hdr_info_t info;
	bmpu_pkg::status_t   final_status;

	// config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dim_q <= bmpu_pkg::MAX_DIM_RST;
		end else if (cfg_valid) begin
			max_dim_q <= cfg_data;
		end
	end

	// input register
	assign blocked  = out_valid & out_stall;
	assign in_stall = valid_s1 & blocked;
	assign proc     = valid_s1 & ~blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			byte_s1 <= file_byte;
			last_s1 <= last_byte;
		end
	end

	// header capture and checks
	bmpu_hdr_check u_hdr (
		.clk          (clk),
		.arst_n       (arst_n),
		.capture      (proc & in_hdr),
		.clear        (proc & last_s1),
		.pos          (count_q[5:0]),
		.data         (byte_s1),
		.max_dim      (max_dim_q),
		.count_next   (count_next),
		.info         (info),
		.final_status (final_status)
	);

	// pixel walker
	always_comb begin
		in_hdr     = count_q[32:6] == '0 && count_q[5:0] < 6'(bmpu_pkg::HDR_BYTES);
		walk       = !in_hdr && info.pass && count_q >= {1'b0, info.data_offset}
			&& rows_done_q < info.height;
		emit       = walk && row_pos_q < info.used;
		row_inc    = row_pos_q + 18'd1;
		row_end    = row_inc >= info.padded;
		count_next = count_q[32] ? count_q : count_q + 33'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			row_pos_q   <= '0;
			rows_done_q <= '0;
		end else if (proc) begin
			if (last_s1) begin
				count_q     <= '0;
				row_pos_q   <= '0;
				rows_done_q <= '0;
			end else begin
				count_q <= count_next;
				if (walk) begin
					row_pos_q <= row_end ? '0 : row_inc;
					if (row_end)
						rows_done_q <= rows_done_q + 16'd1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (proc) begin
			out_valid <= emit | last_s1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			pixel_valid <= emit;
			pixel_byte  <= emit ? byte_s1 : 8'd0;
			stream_done <= last_s1;
			status      <= last_s1 ? final_status : bmpu_pkg::ST_OK;
		end
	end

endmodule

`default_nettype wire

// File: test/tb.sv
// Testbench for bmp_24bit_stream_unpacker: streams BMP files byte by byte and checks
// every pixel/status word against a cycle-free model of the header checks and row walk.
// Depends on bmpu_pkg and the RTL of the unpacker.

module tb;

	localparam int unsigned MAX_GAP          = 12;
	localparam int unsigned HOLD_CYCLES      = 150;
	localparam int unsigned DRAIN_CYCLES     = 8;
	localparam int unsigned RAND_PHASE_BYTES = 50;

	typedef enum logic {ROW_FILE, ROW_SET_MAX} row_kind_t;

	// one line of the file table: a header recipe, or a new max_dimension
	typedef struct {
		row_kind_t          kind;
		logic [15:0]        max_val;
		logic               noise;
		logic [7:0]         m0;
		logic [7:0]         m1;
		logic [31:0]        offset;
		logic [31:0]        width;
		logic [31:0]        height;
		logic [15:0]        bpp;
		logic [31:0]        comp;
		longint unsigned    extra;
		longint unsigned    decl_fix;
		longint             decl_adj;
		longint unsigned    len_fix;
		logic               hold;
		logic               typed;
		bmpu_pkg::status_t  exp_status;
	} file_row_t;

	typedef struct {
		logic               pix_valid;
		logic [7:0]         pix_byte;
		logic               done;
		bmpu_pkg::status_t  st;
	} pixel_word_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  file_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic        pixel_valid;
	logic [7:0]  pixel_byte;
	logic        stream_done;
	logic [2:0]  status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	bmp_24bit_stream_unpacker u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.file_byte   (file_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_valid (pixel_valid),
		.pixel_byte  (pixel_byte),
		.stream_done (stream_done),
		.status      (status),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	// shared between the feeder and the result sink
	pixel_word_t pending_words[$];
	int unsigned mismatches = 0;
	int unsigned bytes_sent = 0;
	logic        burst;
	logic        hold_req;

	// model copy of the register and the stream state
	logic [15:0]     m_max;
	longint unsigned h_count;
	logic [31:0]     h_size;
	logic [31:0]     h_offset;
	logic [31:0]     h_width;
	logic [31:0]     h_height;
	logic [15:0]     h_bpp;
	logic            h_comp;
	logic [1:0]      h_magic;
	logic [17:0]     h_rowpos;
	logic [15:0]     h_rows;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic void clear_header();
		h_count  = 0;
		h_size   = '0;
		h_offset = '0;
		h_width  = '0;
		h_height = '0;
		h_bpp    = '0;
		h_comp   = 1'b0;
		h_magic  = '0;
		h_rowpos = '0;
		h_rows   = '0;
	endfunction

	function automatic longint unsigned padded_row_bytes();
		return ((({32'b0, h_width}) * 3 + 3) / 4) * 4;
	endfunction

	// status in priority order; the size match is only judged on the last byte
	function automatic bmpu_pkg::status_t judge_header(input logic with_size);
		longint unsigned span;
		span = {32'b0, h_offset} + padded_row_bytes() * {32'b0, h_height};
		if (h_count < bmpu_pkg::HDR_BYTES) return bmpu_pkg::ST_SHORT;
		if (h_magic != 2'b11) return bmpu_pkg::ST_MAGIC;
		if (with_size && h_count != {32'b0, h_size}) return bmpu_pkg::ST_SIZE;
		if (h_bpp != bmpu_pkg::BPP_24 || h_comp || h_width == 0 || h_height == 0 ||
				h_width > {16'b0, m_max} || h_height > {16'b0, m_max})
			return bmpu_pkg::ST_FORMAT;
		if (h_offset < bmpu_pkg::HDR_BYTES || span > {32'b0, h_size})
			return bmpu_pkg::ST_OFFSET;
		return bmpu_pkg::ST_OK;
	endfunction

	// advance the model by one accepted byte and queue the word it causes, if any
	function automatic void unpack_step(input logic [7:0] b, input logic last,
			input logic typed, input bmpu_pkg::status_t typed_status);
		int          p;
		logic        emit;
		pixel_word_t w;
		emit = 1'b0;
		if (h_count < bmpu_pkg::HDR_BYTES) begin
			p = int'(h_count);
			if (p == bmpu_pkg::OFS_MAGIC0 && b == bmpu_pkg::MAGIC_B) h_magic[0] = 1'b1;
			if (p == bmpu_pkg::OFS_MAGIC1 && b == bmpu_pkg::MAGIC_M) h_magic[1] = 1'b1;
			if (p >= bmpu_pkg::OFS_SIZE && p < bmpu_pkg::OFS_SIZE + 4)
				h_size[8*(p-bmpu_pkg::OFS_SIZE) +: 8] = b;
			if (p >= bmpu_pkg::OFS_DOFS && p < bmpu_pkg::OFS_DOFS + 4)
				h_offset[8*(p-bmpu_pkg::OFS_DOFS) +: 8] = b;
			if (p >= bmpu_pkg::OFS_WIDTH && p < bmpu_pkg::OFS_WIDTH + 4)
				h_width[8*(p-bmpu_pkg::OFS_WIDTH) +: 8] = b;
			if (p >= bmpu_pkg::OFS_HEIGHT && p < bmpu_pkg::OFS_HEIGHT + 4)
				h_height[8*(p-bmpu_pkg::OFS_HEIGHT) +: 8] = b;
			if (p >= bmpu_pkg::OFS_BPP && p < bmpu_pkg::OFS_BPP + 2)
				h_bpp[8*(p-bmpu_pkg::OFS_BPP) +: 8] = b;
			if (p >= bmpu_pkg::OFS_COMP && p < bmpu_pkg::OFS_COMP + 4 && b != 8'h00)
				h_comp = 1'b1;
		end else if (judge_header(1'b0) == bmpu_pkg::ST_OK &&
				h_count >= {32'b0, h_offset} && {16'b0, h_rows} < h_height) begin
			// row walk: width*3 data bytes, then padding up to 4-byte alignment
			if ({46'b0, h_rowpos} < {32'b0, h_width} * 3) emit = 1'b1;
			h_rowpos = h_rowpos + 18'd1;
			if ({46'b0, h_rowpos} >= padded_row_bytes()) begin
				h_rowpos = '0;
				h_rows   = h_rows + 16'd1;
			end
		end
		if (h_count < 64'h1_0000_0000) h_count++;
		if (emit || last) begin
			w.pix_valid = emit;
			w.pix_byte  = emit ? b : 8'h00;
			w.done      = last;
			w.st        = bmpu_pkg::ST_OK;
			if (last) begin
				w.st = typed ? typed_status : judge_header(1'b1);
				clear_header();
			end
			pending_words.push_back(w);
		end
	endfunction

	function automatic file_row_t mk_file(input logic [7:0] m0, input logic [7:0] m1,
			input logic [31:0] offset, input logic [31:0] width, input logic [31:0] height,
			input logic [15:0] bpp, input logic [31:0] comp, input longint unsigned extra,
			input longint unsigned decl_fix, input longint decl_adj,
			input longint unsigned len_fix, input logic hold, input logic typed,
			input bmpu_pkg::status_t exp_status);
		file_row_t r;
		r.kind       = ROW_FILE;
		r.max_val    = '0;
		r.noise      = 1'b0;
		r.m0         = m0;
		r.m1         = m1;
		r.offset     = offset;
		r.width      = width;
		r.height     = height;
		r.bpp        = bpp;
		r.comp       = comp;
		r.extra      = extra;
		r.decl_fix   = decl_fix;
		r.decl_adj   = decl_adj;
		r.len_fix    = len_fix;
		r.hold       = hold;
		r.typed      = typed;
		r.exp_status = exp_status;
		return r;
	endfunction

	function automatic file_row_t mk_max(input logic [15:0] v);
		file_row_t r;
		r = mk_file(bmpu_pkg::MAGIC_B, bmpu_pkg::MAGIC_M, 0, 0, 0, bmpu_pkg::BPP_24, 0, 0, 0,
			0, 0, 0, 0, bmpu_pkg::ST_OK);
		r.kind    = ROW_SET_MAX;
		r.max_val = v;
		return r;
	endfunction

	// length of a well-formed file: header, gap up to offset, padded rows, trailer
	function automatic longint unsigned file_length(input file_row_t r);
		longint unsigned start;
		start = (r.offset < bmpu_pkg::HDR_BYTES) ? bmpu_pkg::HDR_BYTES : {32'b0, r.offset};
		return start + ((({32'b0, r.width}) * 3 + 3) / 4) * 4 * {32'b0, r.height} + r.extra;
	endfunction

	// mostly good small images, the rest with one defect or pure noise
	function automatic file_row_t random_row();
		file_row_t       r;
		int unsigned     lim_w;
		int unsigned     lim_h;
		longint unsigned nat;
		lim_w = (m_max == 0) ? 1 : ((m_max < 4) ? m_max : 4);
		lim_h = (m_max == 0) ? 1 : ((m_max < 3) ? m_max : 3);
		r = mk_file(bmpu_pkg::MAGIC_B, bmpu_pkg::MAGIC_M,
			bmpu_pkg::HDR_BYTES + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0),
			$urandom_range(1, lim_w), $urandom_range(1, lim_h), bmpu_pkg::BPP_24, 0,
			($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0,
			0, 0, 0, 0, 0, bmpu_pkg::ST_OK);
		nat = file_length(r);
		case ($urandom_range(0, 9))
			6: begin
				case ($urandom_range(0, 5))
					0: r.m0 = 8'($urandom);
					1: r.m1 = 8'($urandom);
					2: r.bpp = 16'($urandom);
					3: r.comp = 32'h1 << $urandom_range(0, 31);
					4: begin
						r.width    = $urandom_range(0, 1) ? 32'd0 : m_max + 32'd1;
						r.decl_fix = 70;
						r.len_fix  = 70;
					end
					default: begin
						r.height   = $urandom_range(0, 1) ? 32'd0 : m_max + 32'd1;
						r.decl_fix = 70;
						r.len_fix  = 70;
					end
				endcase
			end
			7: begin
				if ($urandom_range(0, 1))
					r.decl_adj = $urandom_range(0, 1) ? longint'($urandom_range(1, 3)) :
						-longint'($urandom_range(1, 3));
				else
					r.len_fix = $urandom_range(1, nat - 1);
			end
			8: begin
				if ($urandom_range(0, 1)) begin
					r.offset = $urandom_range(0, bmpu_pkg::HDR_BYTES - 1);
				end else begin
					r.decl_fix = nat - $urandom_range(1, 4);
					r.len_fix  = r.decl_fix;
				end
			end
			9: begin
				r.noise   = 1'b1;
				r.len_fix = $urandom_range(1, 90);
			end
			default: ;
		endcase
		return r;
	endfunction

	// offer one byte, hold it until accepted, then update the model
	task automatic send_word(input logic [7:0] b, input logic last, input logic typed,
			input bmpu_pkg::status_t typed_status);
		int unsigned gap;
		gap = burst ? 0 : $urandom_range(0, MAX_GAP);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		file_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		unpack_step(b, last, typed, typed_status);
	endtask

	// expand one table row into bytes and stream them
	task automatic send_file(input file_row_t r);
		longint unsigned nat;
		longint unsigned len;
		logic [31:0]     decl32;
		logic [7:0]      b;
		int              i;
		burst = r.hold || ($urandom_range(0, 4) == 0);
		if (r.hold) hold_req = 1'b1;
		nat    = file_length(r);
		decl32 = 32'(((r.decl_fix != 0) ? r.decl_fix : nat) + r.decl_adj);
		len    = (r.len_fix != 0) ? r.len_fix : nat;
		for (i = 0; i < len; i++) begin
			b = 8'($urandom);
			if (!r.noise) begin
				if (i == bmpu_pkg::OFS_MAGIC0) b = r.m0;
				else if (i == bmpu_pkg::OFS_MAGIC1) b = r.m1;
				else if (i >= bmpu_pkg::OFS_SIZE && i < bmpu_pkg::OFS_SIZE + 4)
					b = decl32[8*(i-bmpu_pkg::OFS_SIZE) +: 8];
				else if (i >= bmpu_pkg::OFS_DOFS && i < bmpu_pkg::OFS_DOFS + 4)
					b = r.offset[8*(i-bmpu_pkg::OFS_DOFS) +: 8];
				else if (i >= bmpu_pkg::OFS_WIDTH && i < bmpu_pkg::OFS_WIDTH + 4)
					b = r.width[8*(i-bmpu_pkg::OFS_WIDTH) +: 8];
				else if (i >= bmpu_pkg::OFS_HEIGHT && i < bmpu_pkg::OFS_HEIGHT + 4)
					b = r.height[8*(i-bmpu_pkg::OFS_HEIGHT) +: 8];
				else if (i >= bmpu_pkg::OFS_BPP && i < bmpu_pkg::OFS_BPP + 2)
					b = r.bpp[8*(i-bmpu_pkg::OFS_BPP) +: 8];
				else if (i >= bmpu_pkg::OFS_COMP && i < bmpu_pkg::OFS_COMP + 4)
					b = r.comp[8*(i-bmpu_pkg::OFS_COMP) +: 8];
			end
			send_word(b, (i == len - 1), r.typed, r.exp_status);
		end
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// max_dimension only changes with the pipe drained
	task automatic write_max(input logic [15:0] v);
		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		m_max = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// result sink: random stalls, one long hold-off on request
	initial begin : result_sink
		int unsigned hold;
		pixel_word_t w;
		out_stall = 1'b0;
		forever begin
			if (hold_req) begin
				hold     = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				hold = burst ? 0 : $urandom_range(0, MAX_GAP);
			end
			repeat (hold) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			if (pending_words.size() == 0) begin
				$error("word with nothing pending: pixel_valid=%0d pixel_byte=%0d done=%0d st=%0d",
					pixel_valid, pixel_byte, stream_done, status);
				mismatches++;
			end else begin
				w = pending_words.pop_front();
				if (pixel_valid !== w.pix_valid) begin
					$error("pixel_valid: expected %0d, got %0d", w.pix_valid, pixel_valid);
					mismatches++;
				end
				if (pixel_byte !== w.pix_byte) begin
					$error("pixel_byte: expected %0d, got %0d", w.pix_byte, pixel_byte);
					mismatches++;
				end
				if (stream_done !== w.done) begin
					$error("stream_done: expected %0d, got %0d", w.done, stream_done);
					mismatches++;
				end
				if (status !== w.st) begin
					$error("status: expected %0d, got %0d", w.st, status);
					mismatches++;
				end
			end
		end
	end

	// main sequence: reset, file table, then random files under two limits
	initial begin : stimulus
		file_row_t   rows[$];
		int unsigned phase_start;
		int          ph;
		logic [15:0] rand_max;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		file_byte = 8'h00;
		last_byte = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = 16'h0000;
		burst     = 1'b0;
		hold_req  = 1'b0;
		m_max     = bmpu_pkg::MAX_DIM_RST;
		clear_header();

		// limit at reset value
		rows.push_back(mk_file(bmpu_pkg::MAGIC_B, bmpu_pkg::MAGIC_M, 54, 1, 1,
			bmpu_pkg::BPP_24, 0, 0, 0, 0, 0, 0, 1, bmpu_pkg::ST_OK));
		rows.push_back(mk_file(bmpu_pkg::MAGIC_B, bmpu_pkg::MAGIC_M, 54, 1, 1,
			bmpu_pkg::BPP_24, 0, 0, 0, 0, 1, 0, 1, bmpu_pkg::ST_SHORT));
		rows.push_back(mk_file(8'h62, bmpu_pkg::MAGIC_M, 54, 1, 1,
			bmpu_pkg::BPP_24, 0, 0, 0, 0, 0, 0, 1, bmpu_pkg::ST_MAGIC));
		// size mismatch still streams pixels early
		rows.push_back(mk_file(bmpu_pkg::MAGIC_B, bmpu_pkg::MAGIC_M, 54, 2, 2,
			bmpu_pkg::BPP_24, 0, 0, 0, 1, 0, 0, 1, bmpu_pkg::ST_SIZE));
		rows.push_back(mk_file(bmpu_pkg::MAGIC_B, bmpu_pkg::MAGIC_M, 54, 1, 1,
			16'd32, 0, 0, 0, 0, 0, 0, 1, bmpu_pkg::ST_FORMAT));
		// widest row at the reset limit, cut short; sink holds off meanwhile
		rows.push_back(mk_file(bmpu_pkg::MAGIC_B, bmpu_pkg::MAGIC_M, 54, 64000, 1,
			bmpu_pkg::BPP_24, 0, 0, 0, 0, 60, 1, 0, bmpu_pkg::ST_OK));
		// offset inside the header
		rows.push_back(mk_file(bmpu_pkg::MAGIC_B, bmpu_pkg::MAGIC_M, 53, 1, 1,
			bmpu_pkg::BPP_24, 0, 0, 0, 0, 0, 0, 1, bmpu_pkg::ST_OFFSET));
		// zero limit rejects everything
		rows.push_back(mk_max(16'd0));
		rows.push_back(mk_file(bmpu_pkg::MAGIC_B, bmpu_pkg::MAGIC_M, 54, 1, 1,
			bmpu_pkg::BPP_24, 0, 0, 0, 0, 0, 0, 1, bmpu_pkg::ST_FORMAT));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[k]) begin
			if (rows[k].kind == ROW_SET_MAX)
				write_max(rows[k].max_val);
			else
				send_file(rows[k]);
		end

		for (ph = 0; ph < 2; ph++) begin
			case (ph)
				0: rand_max = 16'($urandom_range(2, 6));
				default: rand_max = 16'hFFFF;
			endcase
			write_max(rand_max);
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < RAND_PHASE_BYTES)
				send_file(random_row());
		end

		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// hang guard
	initial begin : watchdog
		#(8 * 600000);
		$display("FAILURE");
		$finish;
	end

endmodule

// File: sim.f
rtl/bmpu_pkg.sv
rtl/bmpu_hdr_check.sv
rtl/bmp_24bit_stream_unpacker.sv
test/tb.sv
